@@ sv/wat_pkg.sv @@
// shared types, codes and date arithmetic for the weekday alarm table matcher
`default_nettype none

package wat_pkg;

    localparam int WAT_ALARM_COUNT = 16;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    localparam logic [3:0] DAY_DAILY   = 4'd7;
    localparam logic [3:0] DAY_ONCE    = 4'd8;
    localparam logic [3:0] DAY_WORK    = 4'd9;
    localparam logic [3:0] DAY_WEEKEND = 4'd10;

    localparam logic [6:0] NO_MINUTE = 7'd127;

    localparam logic [6:0] YEAR_BASE = 7'd20;
    localparam logic [9:0] DAY_BIAS  = 10'd523;

    // 13 * k / 5 for k = 0 .. 16
    localparam logic [5:0] MONTH_TERM [0:16] = '{
        6'd0,  6'd2,  6'd5,  6'd7,  6'd10, 6'd13, 6'd15, 6'd18, 6'd20,
        6'd23, 6'd26, 6'd28, 6'd31, 6'd33, 6'd36, 6'd39, 6'd41
    };

    typedef struct packed {
        logic       en;
        logic [3:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [3:0] tune;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        en: 1'b0, day: DAY_DAILY, hour: 5'd0, minute: 6'd0, tune: 4'd0
    };

    typedef struct packed {
        logic wr;
        logic clr;
    } t_tbl_ctl;

    function automatic logic [9:0] f_weekday_sum(input logic [5:0] yoff,
                                                 input logic [3:0] mon,
                                                 input logic [4:0] dom);
        logic [6:0] y;
        logic [4:0] m;
        logic [4:0] k;
        y = 7'(yoff) + YEAR_BASE;
        m = 5'(mon);
        if (mon <= 4'd2) begin
            m = m + 5'd12;
            y = y - 7'd1;
        end
        k = m + 5'd1;
        return 10'(dom) + 10'(MONTH_TERM[k]) + 10'(y) + 10'(y[6:2]) + DAY_BIAS;
    endfunction

    function automatic logic [2:0] f_mod7(input logic [9:0] x);
        logic [7:0] s1;
        logic [5:0] s2;
        logic [3:0] s3;
        logic [3:0] s4;
        s1 = 8'(x[9:3]) + 8'(x[2:0]);
        s2 = 6'(s1[7:3]) + 6'(s1[2:0]);
        s3 = 4'(s2[5:3]) + 4'(s2[2:0]);
        s4 = 4'(s3[3]) + 4'(s3[2:0]);
        if (s4 >= 4'd7) begin
            s4 = s4 - 4'd7;
        end
        return s4[2:0];
    endfunction

    function automatic logic [10:0] f_minutes(input logic [4:0] hour,
                                              input logic [5:0] minute);
        return (11'(hour) << 6) - (11'(hour) << 2) + 11'(minute);
    endfunction

    function automatic logic f_mult12(input logic [5:0] minute);
        logic [3:0] q;
        q = minute[5:2];
        return (minute[1:0] == 2'd0) &&
               (q == 4'd0 || q == 4'd3 || q == 4'd6 || q == 4'd9 ||
                q == 4'd12 || q == 4'd15);
    endfunction

endpackage

`default_nettype wire

@@ sv/wat_if.sv @@
// valid/ready channel interfaces for input items and results
`default_nettype none

interface wat_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [3:0] entry_index;
    logic       entry_enabled;
    logic [3:0] entry_day;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic [3:0] entry_tune;
    logic [5:0] year_offset;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [4:0] hour_now;
    logic [5:0] minute_now;

    modport source (
        output valid, mode, entry_index, entry_enabled, entry_day, entry_hour,
               entry_minute, entry_tune, year_offset, month, day_of_month,
               hour_now, minute_now,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, entry_enabled, entry_day, entry_hour,
               entry_minute, entry_tune, year_offset, month, day_of_month,
               hour_now, minute_now,
        output ready
    );
endinterface

interface wat_out_if;
    logic       valid;
    logic       ready;
    logic       fire;
    logic [3:0] fired_index;
    logic [3:0] fired_tune;
    logic       alarm_pending;

    modport source (
        output valid, fire, fired_index, fired_tune, alarm_pending,
        input  ready
    );
    modport sink (
        input  valid, fire, fired_index, fired_tune, alarm_pending,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/weekday_alarm_table_matcher_core.sv @@
// alarm table matcher: one item at a time; a write item, or a check of a minute already handled,
// goes straight to the finish state; any other time check computes the weekday, then makes one
// match walk and, when the pending flag is recomputed, one due walk over the table;
// the single table read port sets the walk length; the input is not ready until the result
// has moved into the output register; synchronous active-low reset clears control state and valid bits
`default_nettype none

module weekday_alarm_table_matcher_core import wat_pkg::*; #(
    parameter int ALARM_COUNT = WAT_ALARM_COUNT
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    wat_in_if.sink   i_in,
    wat_out_if.source o_out
);

    localparam int AW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
    localparam int CW = $clog2(ALARM_COUNT + 1);
    localparam int IW = (AW > 4) ? AW : 4;
    localparam logic [CW-1:0] LAST_PTR = CW'(ALARM_COUNT);

    typedef enum logic [2:0] {
        S_IDLE, S_WDAY, S_WMOD, S_SCAN, S_PSCAN, S_FINISH
    } t_state;

    t_state        r_state;
    logic [5:0]    r_yoff;
    logic [3:0]    r_mon;
    logic [4:0]    r_dom;
    logic [4:0]    r_hr;
    logic [5:0]    r_mn;
    logic [9:0]    r_sum;
    logic [10:0]   r_now;
    logic [2:0]    r_wd;
    logic [CW-1:0] r_ptr;
    logic          r_live;
    logic [AW-1:0] r_rd_idx;
    logic [6:0]    r_handled;
    logic          r_pending;
    logic [AW-1:0] r_last;
    logic          r_fire;
    logic [3:0]    r_tune;

    logic          r_ovld;
    logic          r_ofire;
    logic [3:0]    r_oidx;
    logic [3:0]    r_otune;
    logic          r_opend;

    t_tbl_ctl      tbl_ctl;
    logic [AW-1:0] tbl_waddr;
    t_entry        tbl_wdata;
    t_entry        ent;
    logic [IW-1:0] idx_ext;
    logic          idx_ok;
    logic          accept;

    logic          hit_tm;
    logic          day_ok;
    logic          fire_now;
    logic [10:0]   am;
    logic          later;
    logic          earlier;
    logic [2:0]    wd1;
    logic [3:0]    wd4;
    logic          due;

    assign i_in.ready = (r_state == S_IDLE) && i_rst_n;
    assign accept     = i_in.valid && i_in.ready;
    assign idx_ext    = IW'(i_in.entry_index);
    assign idx_ok     = 32'(i_in.entry_index) < 32'(ALARM_COUNT);

    wat_table #(
        .ALARM_COUNT (ALARM_COUNT),
        .AW          (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tbl_ctl),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (ent)
    );

    // entry match and due-within-a-day logic on the entry just read
    always_comb begin
        wd4     = 4'(r_wd);
        wd1     = (r_wd == 3'd6) ? 3'd0 : r_wd + 3'd1;
        hit_tm  = ent.en && (ent.minute == r_mn) && (ent.hour == r_hr);
        day_ok  = (ent.day == DAY_DAILY) || (ent.day == DAY_ONCE) || (ent.day == wd4) ||
                  ((ent.day == DAY_WORK) && (r_wd < 3'd5)) ||
                  ((ent.day == DAY_WEEKEND) && (r_wd >= 3'd5));
        fire_now = r_live && hit_tm && day_ok;
        am      = f_minutes(ent.hour, ent.minute);
        later   = am >= r_now;
        earlier = am <= r_now;
        due     = ent.en && (
                  (ent.day == DAY_DAILY) || (ent.day == DAY_ONCE) ||
                  ((ent.day == wd4) && later) ||
                  ((ent.day == 4'(wd1)) && earlier) ||
                  ((ent.day == DAY_WORK) && ((r_wd < 3'd4) || ((r_wd == 3'd4) && later) ||
                                             ((r_wd == 3'd6) && earlier))) ||
                  ((ent.day == DAY_WEEKEND) && ((r_wd == 3'd5) || ((r_wd == 3'd6) && later) ||
                                                ((r_wd == 3'd4) && earlier))));
    end

    always_comb begin
        tbl_ctl   = '0;
        tbl_waddr = idx_ext[AW-1:0];
        tbl_wdata = '{en: i_in.entry_enabled, day: i_in.entry_day, hour: i_in.entry_hour,
                      minute: i_in.entry_minute, tune: i_in.entry_tune};
        if (accept && (i_in.mode == MODE_WRITE) && idx_ok) begin
            tbl_ctl.wr = 1'b1;
        end
        // one-time entry is erased as it fires
        if ((r_state == S_SCAN) && fire_now && (ent.day == DAY_ONCE)) begin
            tbl_ctl.clr = 1'b1;
            tbl_waddr   = r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_ptr[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= 1'b0;
            r_ptr     <= '0;
            r_handled <= NO_MINUTE;
            r_pending <= 1'b0;
            r_last    <= '0;
            r_fire    <= 1'b0;
            r_tune    <= 4'd0;
            r_ovld    <= 1'b0;
            r_ofire   <= 1'b0;
            r_oidx    <= 4'd0;
            r_otune   <= 4'd0;
            r_opend   <= 1'b0;
        end else begin
            r_live <= 1'b0;
            if (r_ovld && o_out.ready && (r_state != S_FINISH)) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_fire <= 1'b0;
                        r_tune <= 4'd0;
                        r_yoff <= i_in.year_offset;
                        r_mon  <= i_in.month;
                        r_dom  <= i_in.day_of_month;
                        r_hr   <= i_in.hour_now;
                        r_mn   <= i_in.minute_now;
                        if (i_in.mode == MODE_WRITE) begin
                            r_state <= S_FINISH;
                        end else if (r_handled == 7'(i_in.minute_now)) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_handled <= 7'(i_in.minute_now);
                            r_state   <= S_WDAY;
                        end
                    end
                end
                S_WDAY: begin
                    r_sum   <= f_weekday_sum(r_yoff, r_mon, r_dom);
                    r_now   <= f_minutes(r_hr, r_mn);
                    r_state <= S_WMOD;
                end
                S_WMOD: begin
                    r_wd    <= f_mod7(r_sum);
                    r_ptr   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_live && hit_tm) begin
                        r_last <= r_rd_idx;
                    end
                    if (fire_now) begin
                        r_fire <= 1'b1;
                        r_tune <= ent.tune;
                        r_ptr  <= '0;
                        if (ent.day == DAY_ONCE) begin
                            r_state <= S_PSCAN;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end else if (r_ptr < LAST_PTR) begin
                        r_ptr  <= r_ptr + CW'(1);
                        r_live <= 1'b1;
                    end else if (!r_live) begin
                        r_handled <= NO_MINUTE;
                        r_ptr     <= '0;
                        if (f_mult12(r_mn)) begin
                            r_state <= S_PSCAN;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_PSCAN: begin
                    if (r_live && due) begin
                        r_pending <= 1'b1;
                        r_state   <= S_FINISH;
                    end else if (r_ptr < LAST_PTR) begin
                        r_ptr  <= r_ptr + CW'(1);
                        r_live <= 1'b1;
                    end else if (!r_live) begin
                        r_pending <= 1'b0;
                        r_state   <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_ovld || o_out.ready) begin
                        r_ovld  <= 1'b1;
                        r_ofire <= r_fire;
                        r_oidx  <= 4'(r_last);
                        r_otune <= r_tune;
                        r_opend <= r_pending;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_ovld;
    assign o_out.fire          = r_ofire;
    assign o_out.fired_index   = r_oidx;
    assign o_out.fired_tune    = r_otune;
    assign o_out.alarm_pending = r_opend;

endmodule

`default_nettype wire

@@ sv/wat_table.sv @@
// alarm entry memory with per-entry valid bits and registered read
`default_nettype none

module wat_table import wat_pkg::*; #(
    parameter int ALARM_COUNT = WAT_ALARM_COUNT,
    parameter int AW          = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tbl_ctl      i_ctl,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry                 mem [ALARM_COUNT];
    logic [ALARM_COUNT-1:0] r_vld;
    t_entry                 r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_vld[i_waddr] <= 1'b1;
            end else if (i_ctl.clr) begin
                r_vld[i_waddr] <= 1'b0;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_data : ENTRY_RESET;

endmodule

`default_nettype wire

@@ sv/wat_checker.sv @@
// port-level checks for the alarm table matcher, bound to the top level
`default_nettype none

module wat_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire       i_out_fire,
    input wire [3:0] i_out_index,
    input wire [3:0] i_out_tune,
    input wire       i_out_pending
);

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one item at a time: a transfer in closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // no fire means no tune
    a_tune_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_fire |-> i_out_tune == 4'd0)
        else $error("tune without a fire");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_fire) &&
            $stable(i_out_index) && $stable(i_out_tune) && $stable(i_out_pending))
        else $error("stalled result changed");

endmodule

bind weekday_alarm_table_matcher_core wat_checker u_wat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_fire    (o_out.fire),
    .i_out_index   (o_out.fired_index),
    .i_out_tune    (o_out.fired_tune),
    .i_out_pending (o_out.alarm_pending)
);

`default_nettype wire
